// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers used by pth_ctrl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/pth_pkg.sv -----
// ----------------------------------------------------------------------------
// pth_pkg
// shared constants, tables and types of the press timed breathing unit
// ----------------------------------------------------------------------------
package pth_pkg;

    localparam int COUNT_WIDTH     = 16;
    localparam int TABLE_DEPTH     = 64;
    localparam int WAVE_LEN        = 64;
    localparam int IDX_WIDTH       = $clog2(TABLE_DEPTH);
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CMP_WIDTH       = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    localparam logic [7:0] HUE_RED     = 8'd0;
    localparam logic [7:0] HUE_GREEN   = 8'd80;
    localparam logic [7:0] HUE_BLUE    = 8'd160;
    localparam logic [7:0] FULL_SCALE  = 8'd255;
    localparam int         REGION_SPAN = 43;
    localparam int         REGION_STEP = 6;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_GREEN_AFTER  = 2'd0,
        CFG_BLUE_AFTER   = 2'd1,
        CFG_TOGGLE_AFTER = 2'd2,
        CFG_SATURATION   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic take;
        logic prep;
        logic mul;
        logic load;
    } dp_cmd_t;

    typedef logic [7:0] level_t;
    typedef level_t wave_t [WAVE_LEN];
    typedef level_t level_lut_t [TABLE_DEPTH];

    localparam wave_t BREATH_WAVE = '{
        8'd0,   8'd1,   8'd2,   8'd5,   8'd10,  8'd15,  8'd21,  8'd29,
        8'd37,  8'd47,  8'd57,  8'd67,  8'd79,  8'd90,  8'd103, 8'd115,
        8'd128, 8'd140, 8'd152, 8'd165, 8'd176, 8'd188, 8'd198, 8'd208,
        8'd218, 8'd226, 8'd234, 8'd240, 8'd245, 8'd250, 8'd253, 8'd254,
        8'd255, 8'd254, 8'd253, 8'd250, 8'd245, 8'd240, 8'd234, 8'd226,
        8'd218, 8'd208, 8'd198, 8'd188, 8'd176, 8'd165, 8'd152, 8'd140,
        8'd128, 8'd115, 8'd103, 8'd90,  8'd79,  8'd67,  8'd57,  8'd47,
        8'd37,  8'd29,  8'd21,  8'd15,  8'd10,  8'd5,   8'd2,   8'd1
    };

    // brightness per table index, resampled to the configured depth
    function automatic level_lut_t build_level_lut();
        level_lut_t lut;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            lut[i] = BREATH_WAVE[(i * WAVE_LEN) / TABLE_DEPTH];
        end
        return lut;
    endfunction

    localparam level_lut_t LEVEL_LUT = build_level_lut();

endpackage

// ----- rtl/pth_ctrl.sv -----
// ----------------------------------------------------------------------------
// pth_ctrl
// sequencer for one tick: take, prepare, multiply, load result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pth_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output pth_pkg::dp_cmd_t  cmd
);
    import pth_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

    `ASSERT_NEXT(a_one_request_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, cmd.load, !out_valid_reg || m_ready)
    `ASSERT_NEXT(a_load_shows_result, aclk, aresetn, cmd.load, m_valid && s_ready)

endmodule

// ----- rtl/pth_datapath.sv -----
// ----------------------------------------------------------------------------
// pth_datapath
// button hold timers, hue and breathing state, hsv to rgb multiplies
// ----------------------------------------------------------------------------
module pth_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pth_pkg::dp_cmd_t                     cmd,
    input  logic                                 cfg_write,
    input  logic [pth_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [pth_pkg::CFG_WIDTH-1:0]        cfg_wdata,
    input  logic                                 colour_level,
    input  logic                                 mode_level,
    output logic [7:0]                           red,
    output logic [7:0]                           green,
    output logic [7:0]                           blue,
    output logic                                 breathing_on,
    output logic [7:0]                           current_hue
);
    import pth_pkg::*;

    typedef struct packed {
        logic                   prev;
        logic [COUNT_WIDTH-1:0] held;
        logic                   seen;
        logic                   fire;
        logic [COUNT_WIDTH-1:0] dur;
    } button_t;

    function automatic button_t track(input logic level, input logic prev,
                                      input logic [COUNT_WIDTH-1:0] held,
                                      input logic seen);
        button_t b;
        b.prev = level;
        b.held = held;
        b.seen = seen;
        b.fire = 1'b0;
        b.dur  = held;
        if (!level) begin
            if (prev) begin
                b.held = COUNT_WIDTH'(1);
                b.seen = 1'b1;
            end else if (held != '1) begin
                b.held = held + COUNT_WIDTH'(1);
            end
        end else if (!prev) begin
            b.fire = seen;
            b.held = '0;
            b.seen = 1'b0;
        end
        return b;
    endfunction

    logic [CFG_WIDTH-1:0]   green_after_reg;
    logic [CFG_WIDTH-1:0]   blue_after_reg;
    logic [CFG_WIDTH-1:0]   toggle_after_reg;
    logic [7:0]             sat_reg;

    logic                   colour_prev_reg;
    logic                   mode_prev_reg;
    logic [COUNT_WIDTH-1:0] colour_held_reg;
    logic [COUNT_WIDTH-1:0] mode_held_reg;
    logic                   colour_seen_reg;
    logic                   mode_seen_reg;
    logic [7:0]             hue_reg;
    logic [7:0]             hue_next;
    logic                   breathing_reg;
    logic                   breathing_next;
    logic [IDX_WIDTH-1:0]   table_index_reg;
    logic [IDX_WIDTH-1:0]   table_index_next;
    logic [7:0]             value_reg;
    logic [7:0]             value_next;

    logic [2:0]             region_reg;
    logic [2:0]             region_next;
    logic [7:0]             rem_reg;
    logic [7:0]             rem_next;
    logic [7:0]             region_base;

    logic [7:0]             sat_rem_reg;
    logic [7:0]             sat_inv_reg;
    logic [7:0]             p_reg;
    logic [15:0]            sat_rem_prod;
    logic [15:0]            sat_inv_prod;
    logic [15:0]            p_prod;
    logic [15:0]            q_prod;
    logic [15:0]            t_prod;
    logic [7:0]             q_val;
    logic [7:0]             t_val;

    logic [7:0]             red_reg;
    logic [7:0]             green_reg;
    logic [7:0]             blue_reg;
    logic                   breathing_out_reg;
    logic [7:0]             hue_out_reg;
    logic [7:0]             red_next;
    logic [7:0]             green_next;
    logic [7:0]             blue_next;

    button_t colour_b;
    button_t mode_b;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            green_after_reg  <= CFG_WIDTH'(200);
            blue_after_reg   <= CFG_WIDTH'(400);
            toggle_after_reg <= CFG_WIDTH'(200);
            sat_reg          <= FULL_SCALE;
        end else if (cfg_write) begin
            case (cfg_index_t'(cfg_index))
                CFG_GREEN_AFTER:  green_after_reg  <= cfg_wdata;
                CFG_BLUE_AFTER:   blue_after_reg   <= cfg_wdata;
                CFG_TOGGLE_AFTER: toggle_after_reg <= cfg_wdata;
                CFG_SATURATION:   sat_reg          <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // button tracking, hue select, breathing toggle and brightness select
    always_comb begin
        colour_b = track(colour_level, colour_prev_reg, colour_held_reg, colour_seen_reg);
        mode_b   = track(mode_level, mode_prev_reg, mode_held_reg, mode_seen_reg);

        hue_next = hue_reg;
        if (colour_b.fire) begin
            if (CMP_WIDTH'(colour_b.dur) > CMP_WIDTH'(blue_after_reg)) begin
                hue_next = HUE_BLUE;
            end else if (CMP_WIDTH'(colour_b.dur) > CMP_WIDTH'(green_after_reg)) begin
                hue_next = HUE_GREEN;
            end else if (colour_b.dur != '0) begin
                hue_next = HUE_RED;
            end
        end

        breathing_next = breathing_reg;
        if (mode_b.fire && (CMP_WIDTH'(mode_b.dur) > CMP_WIDTH'(toggle_after_reg))) begin
            breathing_next = !breathing_reg;
        end

        table_index_next = table_index_reg;
        value_next       = FULL_SCALE;
        if (breathing_next) begin
            value_next = LEVEL_LUT[table_index_reg];
            if (table_index_reg == IDX_WIDTH'(TABLE_DEPTH - 1)) begin
                table_index_next = '0;
            end else begin
                table_index_next = table_index_reg + IDX_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colour_prev_reg <= 1'b1;
            mode_prev_reg   <= 1'b1;
            colour_held_reg <= '0;
            mode_held_reg   <= '0;
            colour_seen_reg <= 1'b0;
            mode_seen_reg   <= 1'b0;
            hue_reg         <= HUE_RED;
            breathing_reg   <= 1'b0;
            table_index_reg <= '0;
        end else if (cmd.take) begin
            colour_prev_reg <= colour_b.prev;
            mode_prev_reg   <= mode_b.prev;
            colour_held_reg <= colour_b.held;
            mode_held_reg   <= mode_b.held;
            colour_seen_reg <= colour_b.seen;
            mode_seen_reg   <= mode_b.seen;
            hue_reg         <= hue_next;
            breathing_reg   <= breathing_next;
            table_index_reg <= table_index_next;
        end
    end

    // hue region and remainder
    always_comb begin
        if (hue_reg < 8'(REGION_SPAN)) begin
            region_next = 3'd0;
            region_base = 8'd0;
        end else if (hue_reg < 8'(2 * REGION_SPAN)) begin
            region_next = 3'd1;
            region_base = 8'(REGION_SPAN);
        end else if (hue_reg < 8'(3 * REGION_SPAN)) begin
            region_next = 3'd2;
            region_base = 8'(2 * REGION_SPAN);
        end else if (hue_reg < 8'(4 * REGION_SPAN)) begin
            region_next = 3'd3;
            region_base = 8'(3 * REGION_SPAN);
        end else if (hue_reg < 8'(5 * REGION_SPAN)) begin
            region_next = 3'd4;
            region_base = 8'(4 * REGION_SPAN);
        end else begin
            region_next = 3'd5;
            region_base = 8'(5 * REGION_SPAN);
        end
        rem_next = 8'((hue_reg - region_base) * 8'(REGION_STEP));
    end

    // first and second multiply rows
    assign sat_rem_prod = 16'(sat_reg) * 16'(rem_reg);
    assign sat_inv_prod = 16'(sat_reg) * 16'(FULL_SCALE - rem_reg);
    assign p_prod       = 16'(value_reg) * 16'(FULL_SCALE - sat_reg);
    assign q_prod       = 16'(value_reg) * 16'(FULL_SCALE - sat_rem_reg);
    assign t_prod       = 16'(value_reg) * 16'(FULL_SCALE - sat_inv_reg);
    assign q_val        = q_prod[15:8];
    assign t_val        = t_prod[15:8];

    always_comb begin
        red_next   = value_reg;
        green_next = value_reg;
        blue_next  = value_reg;
        if (sat_reg != 8'd0) begin
            case (region_reg)
                3'd0: begin
                    red_next = value_reg; green_next = t_val; blue_next = p_reg;
                end
                3'd1: begin
                    red_next = q_val; green_next = value_reg; blue_next = p_reg;
                end
                3'd2: begin
                    red_next = p_reg; green_next = value_reg; blue_next = t_val;
                end
                3'd3: begin
                    red_next = p_reg; green_next = q_val; blue_next = value_reg;
                end
                3'd4: begin
                    red_next = t_val; green_next = p_reg; blue_next = value_reg;
                end
                default: begin
                    red_next = value_reg; green_next = p_reg; blue_next = q_val;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            value_reg <= value_next;
        end
        if (cmd.prep) begin
            region_reg <= region_next;
            rem_reg    <= rem_next;
        end
        if (cmd.mul) begin
            sat_rem_reg <= sat_rem_prod[15:8];
            sat_inv_reg <= sat_inv_prod[15:8];
            p_reg       <= p_prod[15:8];
        end
        if (cmd.load) begin
            red_reg           <= red_next;
            green_reg         <= green_next;
            blue_reg          <= blue_next;
            breathing_out_reg <= breathing_reg;
            hue_out_reg       <= hue_reg;
        end
    end

    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign breathing_on = breathing_out_reg;
    assign current_hue  = hue_out_reg;

endmodule

// ----- rtl/press_timed_led_breathing_hsv_unit.sv -----
// a request is taken, then passes the region and multiply steps, and its result
// is registered in the load step, which waits while an earlier result is untaken
// a new request is taken only once the last is loaded; the result register
// then frees the input side while a result waits. reset: aresetn low at a
// rising edge clears control, hold timer, hue, breathing and config registers
// ----------------------------------------------------------------------------
// press_timed_led_breathing_hsv_unit
// button hold timing selects hue and breathing, output is 8-bit rgb per tick
// ----------------------------------------------------------------------------
module press_timed_led_breathing_hsv_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_colour_button_level,
    input  logic                                 s_mode_button_level,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [7:0]                           m_red,
    output logic [7:0]                           m_green,
    output logic [7:0]                           m_blue,
    output logic                                 m_breathing_on,
    output logic [7:0]                           m_current_hue,
    input  logic                                 cfg_write,
    input  logic [pth_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [pth_pkg::CFG_WIDTH-1:0]        cfg_wdata
);
    import pth_pkg::*;

    dp_cmd_t cmd;

    pth_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pth_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .colour_level (s_colour_button_level),
        .mode_level   (s_mode_button_level),
        .red          (m_red),
        .green        (m_green),
        .blue         (m_blue),
        .breathing_on (m_breathing_on),
        .current_hue  (m_current_hue)
    );

endmodule

// ----- tb/tb_press_timed_led_breathing_hsv_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_press_timed_led_breathing_hsv_unit
// self-checking bench: button tick requests go in, each accepted request is
// run through a local model of hold timing, breathing and hsv conversion, and
// the rgb results are compared field by field in order, under random stalls
// ----------------------------------------------------------------------------
module tb_press_timed_led_breathing_hsv_unit;
    import pth_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_TICKS    = 130;

    localparam logic [7:0] BREATH_LEVELS [64] = '{
        8'd0,   8'd1,   8'd2,   8'd5,   8'd10,  8'd15,  8'd21,  8'd29,
        8'd37,  8'd47,  8'd57,  8'd67,  8'd79,  8'd90,  8'd103, 8'd115,
        8'd128, 8'd140, 8'd152, 8'd165, 8'd176, 8'd188, 8'd198, 8'd208,
        8'd218, 8'd226, 8'd234, 8'd240, 8'd245, 8'd250, 8'd253, 8'd254,
        8'd255, 8'd254, 8'd253, 8'd250, 8'd245, 8'd240, 8'd234, 8'd226,
        8'd218, 8'd208, 8'd198, 8'd188, 8'd176, 8'd165, 8'd152, 8'd140,
        8'd128, 8'd115, 8'd103, 8'd90,  8'd79,  8'd67,  8'd57,  8'd47,
        8'd37,  8'd29,  8'd21,  8'd15,  8'd10,  8'd5,   8'd2,   8'd1
    };

    typedef struct packed {
        logic colour;
        logic mode;
    } tick_t;

    typedef struct packed {
        logic        prev;
        logic [15:0] held;
        logic        seen;
    } button_t;

    typedef struct packed {
        button_t     state;
        logic        ended;
        logic [15:0] duration;
    } button_step_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       breathing_on;
        logic [7:0] hue;
    } led_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_colour_button_level = 1'b1;
    logic        s_mode_button_level = 1'b1;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic        m_breathing_on;
    logic [7:0]  m_current_hue;
    logic        cfg_write = 1'b0;
    cfg_index_t  cfg_index = CFG_GREEN_AFTER;
    logic [15:0] cfg_wdata = '0;

    tick_t tick_queue [$];
    led_t  expected_leds [$];
    int    mismatches = 0;
    int    queued_ticks = 0;
    int    results_seen = 0;
    int    quiet_cycles = 0;
    int    hold_requests = 0;
    int    hold_served = 0;
    int    rx_hold_left = 0;
    int    rx_idle_left = 0;
    int    tx_idle_left = 0;
    bit    req_accepted = 1'b0;
    bit    no_idle = 1'b0;

    // model state and register copies
    button_t     colour_btn;
    button_t     mode_btn;
    logic [7:0]  hue_now;
    logic        breathing_now;
    logic [5:0]  wave_index;
    logic [15:0] green_after;
    logic [15:0] blue_after;
    logic [15:0] toggle_after;
    logic [7:0]  sat_level;

    press_timed_led_breathing_hsv_unit dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_colour_button_level (s_colour_button_level),
        .s_mode_button_level   (s_mode_button_level),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_red                 (m_red),
        .m_green               (m_green),
        .m_blue                (m_blue),
        .m_breathing_on        (m_breathing_on),
        .m_current_hue         (m_current_hue),
        .cfg_write             (cfg_write),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic button_step_t step_button(button_t b, logic level);
        button_step_t r;
        r.state    = b;
        r.ended    = 1'b0;
        r.duration = '0;
        if (!level) begin
            if (b.prev) begin
                r.state.held = 16'd1;
                r.state.seen = 1'b1;
            end else if (b.held != 16'hFFFF) begin
                r.state.held = b.held + 16'd1;
            end
        end else if (!b.prev) begin
            r.ended      = b.seen;
            r.duration   = b.held;
            r.state.held = '0;
            r.state.seen = 1'b0;
        end
        r.state.prev = level;
        return r;
    endfunction

    function automatic led_t hsv_to_rgb8(logic [7:0] h, logic [7:0] s, logic [7:0] v);
        int   region, rem, p, q, t;
        led_t c;
        c = '0;
        if (s == 8'd0) begin
            c.red   = v;
            c.green = v;
            c.blue  = v;
        end else begin
            region = int'(h) / REGION_SPAN;
            rem    = (int'(h) - region * REGION_SPAN) * REGION_STEP;
            p = ((int'(v) * (255 - int'(s))) >> 8) & 255;
            q = ((int'(v) * (255 - ((int'(s) * rem) >> 8))) >> 8) & 255;
            t = ((int'(v) * (255 - ((int'(s) * (255 - rem)) >> 8))) >> 8) & 255;
            case (region)
                0: begin c.red = v;     c.green = t[7:0]; c.blue = p[7:0]; end
                1: begin c.red = q[7:0]; c.green = v;     c.blue = p[7:0]; end
                2: begin c.red = p[7:0]; c.green = v;     c.blue = t[7:0]; end
                3: begin c.red = p[7:0]; c.green = q[7:0]; c.blue = v;     end
                4: begin c.red = t[7:0]; c.green = p[7:0]; c.blue = v;     end
                default: begin c.red = v; c.green = p[7:0]; c.blue = q[7:0]; end
            endcase
        end
        return c;
    endfunction

    function automatic led_t predict_led(tick_t tk);
        button_step_t cs, ms;
        logic [7:0]   level;
        led_t         c;
        cs = step_button(colour_btn, tk.colour);
        colour_btn = cs.state;
        if (cs.ended) begin
            if (cs.duration > blue_after) begin
                hue_now = HUE_BLUE;
            end else if (cs.duration > green_after) begin
                hue_now = HUE_GREEN;
            end else if (cs.duration > 16'd0) begin
                hue_now = HUE_RED;
            end
        end
        ms = step_button(mode_btn, tk.mode);
        mode_btn = ms.state;
        if (ms.ended && ms.duration > toggle_after) begin
            breathing_now = ~breathing_now;
        end
        if (breathing_now) begin
            level = BREATH_LEVELS[wave_index];
            wave_index = wave_index + 6'd1;
        end else begin
            level = FULL_SCALE;
        end
        c = hsv_to_rgb8(hue_now, sat_level, level);
        c.breathing_on = breathing_now;
        c.hue = hue_now;
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic set_reg(cfg_index_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_GREEN_AFTER:  green_after = val;
            CFG_BLUE_AFTER:   blue_after = val;
            CFG_TOGGLE_AFTER: toggle_after = val;
            CFG_SATURATION:   sat_level = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(int g, int b, int t, int s);
        set_reg(CFG_GREEN_AFTER, g[15:0]);
        set_reg(CFG_BLUE_AFTER, b[15:0]);
        set_reg(CFG_TOGGLE_AFTER, t[15:0]);
        set_reg(CFG_SATURATION, s[15:0]);
        @(negedge aclk);
        cfg_write <= 1'b0;
        @(posedge aclk);
    endtask

    // colour and mode held low for the given ticks, then released for gap ticks
    task automatic queue_holds(int colour_ticks, int mode_ticks, int gap);
        tick_t tk;
        int    span;
        span = (colour_ticks > mode_ticks) ? colour_ticks : mode_ticks;
        for (int i = 0; i < span + gap; i++) begin
            tk.colour = (i >= colour_ticks);
            tk.mode   = (i >= mode_ticks);
            tick_queue.push_back(tk);
            queued_ticks++;
        end
    endtask

    task automatic queue_noise(int n);
        tick_t tk;
        for (int i = 0; i < n; i++) begin
            tk.colour = $urandom_range(0, 1);
            tk.mode   = $urandom_range(0, 1);
            tick_queue.push_back(tk);
            queued_ticks++;
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (results_seen != queued_ticks) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random_phase();
        int start, kind, ct, mt;
        start = queued_ticks;
        while (queued_ticks - start < PHASE_TICKS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                ct = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 45) : 0;
                mt = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 45) : 0;
                if (ct == 0 && mt == 0) begin
                    ct = $urandom_range(1, 45);
                end
                queue_holds(ct, mt, $urandom_range(1, 3));
            end else begin
                queue_noise($urandom_range(1, 8));
            end
        end
    endtask

    // request driver
    always @(negedge aclk) begin : request_driver
        tick_t tk;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_accepted) begin
            if (tx_idle_left > 0) begin
                tx_idle_left--;
                s_valid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 15) == 0) begin
                tx_idle_left = $urandom_range(0, 14);
                s_valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
                tk = tick_queue.pop_front();
                s_colour_button_level <= tk.colour;
                s_mode_button_level   <= tk.mode;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin : result_receiver
        logic ready_next;
        ready_next = 1'b1;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            ready_next = 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served++;
            rx_hold_left = RX_HOLD_CYCLES - 1;
            ready_next = 1'b0;
        end else if (rx_idle_left > 0) begin
            rx_idle_left--;
            ready_next = 1'b0;
        end else if (!no_idle && $urandom_range(0, 15) == 0) begin
            rx_idle_left = $urandom_range(0, 14);
            ready_next = 1'b0;
        end
        m_ready <= aresetn && ready_next;
    end

    // result checker, prediction and watchdog
    always @(posedge aclk) begin : led_checker
        led_t  want;
        tick_t tk;
        if (!aresetn) begin
            req_accepted = 1'b0;
            quiet_cycles = 0;
        end else begin
            req_accepted = s_valid && s_ready;
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_leds.size() == 0) begin
                    report_mismatch("result with none pending, red", m_red, 0);
                end else begin
                    want = expected_leds.pop_front();
                    if (m_red != want.red)
                        report_mismatch("red", m_red, want.red);
                    if (m_green != want.green)
                        report_mismatch("green", m_green, want.green);
                    if (m_blue != want.blue)
                        report_mismatch("blue", m_blue, want.blue);
                    if (m_breathing_on != want.breathing_on)
                        report_mismatch("breathing_on", m_breathing_on, want.breathing_on);
                    if (m_current_hue != want.hue)
                        report_mismatch("current_hue", m_current_hue, want.hue);
                end
            end
            if (req_accepted) begin
                tk.colour = s_colour_button_level;
                tk.mode   = s_mode_button_level;
                expected_leds.push_back(predict_led(tk));
            end
            if (req_accepted || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        colour_btn    = '{prev: 1'b1, held: '0, seen: 1'b0};
        mode_btn      = '{prev: 1'b1, held: '0, seen: 1'b0};
        hue_now       = HUE_RED;
        breathing_now = 1'b0;
        wave_index    = '0;
        green_after   = 16'd200;
        blue_after    = 16'd400;
        toggle_after  = 16'd200;
        sat_level     = 8'd255;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values in use
        queue_holds(0, 0, 2);
        queue_holds(2, 2, 1);
        wait_drained();

        // hue and toggle boundaries around small limits
        apply_settings(2, 4, 3, 255);
        queue_holds(3, 0, 1);
        queue_holds(5, 0, 1);
        queue_holds(2, 0, 1);
        queue_holds(0, 4, 1);
        queue_holds(0, 3, 1);
        queue_holds(3, 5, 2);
        wait_drained();

        // zero green limit, long holds under high limits, grey output
        apply_settings(0, 65534, 65534, 0);
        queue_holds(1, 0, 1);
        queue_holds(40, 40, 2);
        wait_drained();

        // top limits never exceeded
        apply_settings(65535, 65535, 65535, 255);
        queue_holds(3, 3, 1);
        queue_noise(4);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: apply_settings($urandom_range(0, 20), $urandom_range(0, 40),
                                  $urandom_range(0, 30), 0);
                1: apply_settings($urandom_range(0, 20), $urandom_range(0, 40),
                                  $urandom_range(0, 30), 255);
                default: apply_settings($urandom_range(0, 20), $urandom_range(0, 40),
                                        $urandom_range(0, 30), $urandom_range(0, 255));
            endcase
            if (ph == RANDOM_PHASES - 1) begin
                no_idle = 1'b1;
            end
            run_random_phase();
            // long receiver stall while requests keep coming
            if (ph == 2) begin
                hold_requests++;
            end
            wait_drained();
        end

        if (expected_leds.size() != 0) begin
            report_mismatch("results never seen", 0, expected_leds.size());
        end
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
